/* src/shash_pkg.sv */
// ----------------------------------------------------------------------------
// shash_pkg
// Round constants, initial hash values and the SHA-256 mixing functions
// shared by the stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shash_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned ROUNDS      = 64;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

/* src/sha256_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Byte-serial SHA-256: collects 64-byte blocks, compresses each with one
// round unit reused for every round, pads the message and returns the digest.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready  | data_byte, last_byte
//  out     | output    | out_valid / out_ready| digest_word, word_index, last_word
//
// Bytes are accepted one per cycle while in_ready is high. The 64th byte of
// a block starts the compression: every round passes through the single round
// unit (ST_ROUND), then ST_ADD folds the working words into the chaining words.
// After the final byte the pad and length bytes are written one per cycle,
// with one or two compressions, then eight digest words follow.
// in_ready is low during every compression, and from the final byte until the
// last digest word is taken; a stalled out_ready holds the current word. Reset
// loads the initial hash and clears the fill level and bit count.
`default_nettype none

module sha256_stream_hasher_top
    import shash_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    state_t      state_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic [2:0]  word_reg;
    logic        pad_busy_reg;
    logic        pad_first_reg;
    logic        len_phase_reg;
    logic        len_done_reg;

    logic [31:0] h_reg [HASH_WORDS];
    logic [31:0] v_reg [HASH_WORDS];
    logic [31:0] w_reg [BLOCK_WORDS];

    logic        in_accept;
    logic        byte_we;
    logic        len_byte;
    logic        block_full;
    logic [7:0]  pad_byte;
    logic [7:0]  byte_val;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] w_next;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = h_reg[0];
    assign word_index  = word_reg;
    assign last_word   = (word_reg == LAST_WORD_IDX);

    // Once the pad byte is in, the length goes into the last eight slots of the
    // first block that reaches slot 56.
    assign len_byte = (state_reg == ST_PAD) && !pad_first_reg
                      && (len_phase_reg || fill_reg == LEN_START);

    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (len_byte)
        begin
            pad_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    assign byte_we    = in_accept || (state_reg == ST_PAD);
    assign byte_val   = (state_reg == ST_IDLE) ? data_byte : pad_byte;
    assign block_full = byte_we && (fill_reg == LAST_SLOT);

    // One compression round and one schedule step per cycle.
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[round_reg] + w_reg[0];
    assign t2  = big_sigma0(v_reg[0]) + maj;
    assign w_next = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            round_reg     <= '0;
            word_reg      <= '0;
            pad_busy_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            len_done_reg  <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                h_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        bits_reg <= bits_reg + BITS_PER_BYTE;
                        if (last_byte)
                        begin
                            pad_busy_reg  <= 1'b1;
                            pad_first_reg <= 1'b1;
                        end
                        if (block_full)
                        begin
                            state_reg <= ST_ROUND;
                        end
                        else if (last_byte)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    fill_reg      <= fill_reg + 6'd1;
                    pad_first_reg <= 1'b0;
                    if (len_byte)
                    begin
                        len_phase_reg <= 1'b1;
                        if (fill_reg == LAST_SLOT)
                        begin
                            len_done_reg <= 1'b1;
                        end
                    end
                    if (block_full)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    // The counter wraps to zero after the last round.
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == LAST_ROUND)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < HASH_WORDS; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (len_done_reg)
                    begin
                        state_reg <= ST_OUT;
                        word_reg  <= '0;
                    end
                    else if (pad_busy_reg)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        // Shift the digest out and the initial hash in behind it.
                        for (int i = 0; i < HASH_WORDS - 1; i++)
                        begin
                            h_reg[i] <= h_reg[i + 1];
                        end
                        h_reg[HASH_WORDS - 1] <= INIT_HASH[word_reg];
                        word_reg <= word_reg + 3'd1;
                        if (word_reg == LAST_WORD_IDX)
                        begin
                            state_reg     <= ST_IDLE;
                            bits_reg      <= '0;
                            pad_busy_reg  <= 1'b0;
                            len_phase_reg <= 1'b0;
                            len_done_reg  <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Block words and working variables carry no reset.
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= byte_val;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[BLOCK_WORDS - 1] <= w_next;
        end

        if (block_full)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

endmodule

`default_nettype wire

/* test/sha256_stream_hasher_tb.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher testbench
// Streams messages into the byte-serial SHA-256 hasher and checks every
// digest word against a software SHA-256 kept in step with the accepted
// bytes. A short table of directed messages (one known digest among them)
// comes first, then random messages whose lengths favor the padding
// boundaries. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
    import shash_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         known;
        logic [255:0] digest;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // Software copy of the hasher state.
    logic [31:0] chain_words [HASH_WORDS];
    logic [7:0]  block_buf [64];
    logic [63:0] total_bits;
    logic [5:0]  fill_count;

    digest_item_t pending_words [$];
    int err_count = 0;
    int cycle_count = 0;
    bit quiet_phase;

    // Directed messages: "abc" with its published digest, single-byte
    // messages at the byte extremes and at the pad value, a short mixed one and a two-byte one.
    stim_row_t directed_rows [16] = '{
        '{8'h61, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1,
          256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad},
        '{8'h00, 1'b1, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 256'h0},
        '{8'h80, 1'b1, 1'b0, 256'h0},
        '{8'h00, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b0, 1'b0, 256'h0},
        '{8'haa, 1'b0, 1'b0, 256'h0},
        '{8'h55, 1'b0, 1'b0, 256'h0},
        '{8'h01, 1'b0, 1'b0, 256'h0},
        '{8'h80, 1'b0, 1'b0, 256'h0},
        '{8'h7f, 1'b0, 1'b0, 256'h0},
        '{8'hfe, 1'b1, 1'b0, 256'h0},
        '{8'hff, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 256'h0}
    };

    sha256_stream_hasher_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] doubled;
        doubled = {x, x} >> n;
        return doubled[31:0];
    endfunction

    function automatic void restart_hash();
        chain_words = INIT_HASH;
        total_bits  = '0;
        fill_count  = '0;
    endfunction

    function automatic void compress_chain();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
        e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & f) ^ (~e & g)) + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
        chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        block_buf[fill_count] = value;
        fill_count = fill_count + 6'd1;
        if (fill_count == 6'd0)
            compress_chain();
    endfunction

    // Returns 1 and the digest when the byte closes a message.
    function automatic bit absorb_message_byte(input logic [7:0] value, input logic final_byte,
                                               output logic [255:0] digest);
        logic [63:0] length_bits;
        digest = '0;
        absorb_byte(value);
        total_bits = total_bits + BITS_PER_BYTE;
        if (!final_byte)
            return 1'b0;
        length_bits = total_bits;
        absorb_byte(PAD_BYTE);
        while (fill_count != LEN_START)
            absorb_byte(8'h00);
        for (int i = 7; i >= 0; i--)
            absorb_byte(length_bits[8*i +: 8]);
        for (int j = 0; j < HASH_WORDS; j++)
            digest[255 - 32*j -: 32] = chain_words[j];
        restart_hash();
        return 1'b1;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h (cycle %0d)", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    // Entered and left just after a falling edge.
    task automatic drive_byte(input logic [7:0] value, input logic final_byte,
                              input logic use_known, input logic [255:0] known_digest);
        logic [255:0] predicted;
        bit           produced;
        int           gap;
        gap = quiet_phase ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = value;
        last_byte = final_byte;
        do
            @(posedge clk);
        while (!in_ready);
        produced = absorb_message_byte(value, final_byte, predicted);
        if (produced)
        begin
            if (use_known)
                predicted = known_digest;
            for (int j = 0; j < HASH_WORDS; j++)
                pending_words.push_back('{word:  predicted[255 - 32*j -: 32],
                                          index: 3'(j),
                                          last:  3'(j) == LAST_WORD_IDX});
        end
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped by cycle limit at %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected digest word", digest_word, 32'h0);
            else
            begin
                want = pending_words.pop_front();
                if (digest_word !== want.word)
                    report_mismatch("digest_word", digest_word, want.word);
                if (word_index !== want.index)
                    report_mismatch("word_index", 32'(word_index), 32'(want.index));
                if (last_word !== want.last)
                    report_mismatch("last_word", 32'(last_word), 32'(want.last));
            end
        end
    end

    // Output side: bursts of ready broken by stalls, none in quiet phases.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            out_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            stall = quiet_phase ? 0 : idle_length();
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    initial
    begin
        int          boundary_lens [8];
        int          random_items;
        int          msg_len;
        int          pattern;
        int          pick;
        logic [7:0]  value;
        boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        last_byte   = 1'b0;
        quiet_phase = 1'b0;
        random_items = 0;
        restart_hash();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            drive_byte(directed_rows[i].data, directed_rows[i].last,
                       directed_rows[i].known, directed_rows[i].digest);

        // Random messages; lengths lean toward the one- and two-block padding edges.
        while (random_items < RANDOM_ITEMS)
        begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                msg_len = $urandom_range(1, 12);
            else if (pick < 80)
                msg_len = boundary_lens[3'($urandom_range(0, 7))];
            else
                msg_len = $urandom_range(13, 100);
            pattern = $urandom_range(0, 9);
            for (int k = 0; k < msg_len; k++)
            begin
                if (pattern == 0)
                    value = 8'h00;
                else if (pattern == 1)
                    value = 8'hff;
                else
                    value = 8'($urandom_range(0, 255));
                drive_byte(value, k == msg_len - 1, 1'b0, 256'h0);
                random_items++;
            end
        end
        quiet_phase = 1'b0;
        in_valid    = 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
